// ----- rtl/sssv_pkg.sv -----
// Package for the step-sequenced synth voice.
// Holds step count, gains, decay factors, note frequency and sine tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sssv_pkg;

    localparam int STEPS = 8;
    localparam int STEP_W = 3;

    localparam logic [31:0] LPF_COEF  = 32'd6554;
    localparam logic [31:0] BASS_GAIN = 32'd19661;
    localparam logic [31:0] ARP_GAIN  = 32'd13107;
    localparam logic [31:0] KICK_GAIN = 32'd26214;
    localparam logic [31:0] NZ_GAIN   = 32'd13107;
    localparam logic [31:0] BASS_DEC  = 32'd65470;
    localparam logic [31:0] ARP_DEC   = 32'd65208;
    localparam logic [31:0] DRUM_DEC  = 32'd64881;
    localparam logic [31:0] KICK_FREQ = 32'd55 << 16;
    localparam logic [16:0] ENV_FULL  = 17'd65536;
    localparam logic signed [15:0] SQ_AMP = 16'sd9830;

    localparam logic [2:0] REG_BEAT_INC = 3'd0;
    localparam logic [2:0] REG_VOLUME   = 3'd1;
    localparam logic [2:0] REG_BASS     = 3'd2;
    localparam logic [2:0] REG_ARP      = 3'd3;
    localparam logic [2:0] REG_DRUM     = 3'd4;
    localparam logic [2:0] REG_ENABLE   = 3'd5;

    localparam logic [31:0] TOP_OCTAVE [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480575,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616230, 32'd1035748353
    };

    localparam logic [14:0] QUARTER_SINE [17] = '{
        15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12539, 15'd15446, 15'd18204,
        15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898, 15'd30273,
        15'd31356, 15'd32137, 15'd32609, 15'd32767
    };

    function automatic logic [31:0] note_freq(input logic [6:0] n);
        logic [3:0] oct;
        logic [6:0] rem;
        oct = 4'd0;
        for (int k = 1; k <= 10; k++)
        begin
            if (n >= 7'(12 * k))
                oct = 4'(k);
        end
        rem = n - 7'(12 * oct);
        return TOP_OCTAVE[rem[3:0]] >> (4'd10 - oct);
    endfunction

    function automatic logic signed [15:0] sine64(input logic [5:0] i);
        logic [4:0] j;
        logic [14:0] q;
        j = {1'b0, i[3:0]};
        if (i[4])
            q = QUARTER_SINE[5'd16 - j];
        else
            q = QUARTER_SINE[j];
        if (i[5])
            return -$signed({1'b0, q});
        return $signed({1'b0, q});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/step_sequenced_synth_voice.sv -----
// Top level of the step-sequenced synth voice: sequencer, digit-serial multiplier.
// Depends on sssv_pkg.
// When enabled, a request runs up to 16 multiplies, each as operand load, eight
// radix-16 digit steps and writeback; a disabled request skips the multiplier.
// One request at a time: s_tready is high only in idle; all ops share one 4-bit digit multiplier.
// Reset: asynchronous active low; FSM, config and voice state cleared, volume 1.0.
`timescale 1ns / 1ps
`default_nettype none

module step_sequenced_synth_voice
    import sssv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [6:0] noise_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [15:0] audio_sample, [16] step_advanced
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_PHASE, ST_LOAD, ST_MUL, ST_USE, ST_DONE} state_t;
    typedef enum logic [3:0] {
        OP_BFREQ, OP_LPF, OP_BX, OP_BG, OP_BDEC,
        OP_AFREQ, OP_AX, OP_AG, OP_ADEC,
        OP_KFREQ, OP_KX, OP_KG, OP_NX, OP_NG, OP_DDEC, OP_VOL
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [31:0] beat_inc_reg;
    logic [15:0] volume_reg;
    logic [63:0] bass_notes_reg, arp_notes_reg;
    logic [7:0]  drum_pat_reg;
    logic        enable_reg;

    logic [31:0] phase_reg, phase_next;
    logic [STEP_W-1:0] bstep_reg, bstep_next, astep_reg, astep_next, dstep_reg, dstep_next;
    logic [16:0] benv_reg, benv_next, aenv_reg, aenv_next, denv_reg, denv_next;
    logic signed [15:0] mem_reg, mem_next;
    logic signed [15:0] saw_reg, saw_next;
    logic        sq_pos_reg, sq_pos_next;
    logic [5:0]  kidx_reg, kidx_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [19:0] sum_reg, sum_next;
    logic [6:0]  noise_reg, noise_next;
    logic        bass_on_reg, bass_on_next, arp_on_reg, arp_on_next, drum_on_reg, drum_on_next;
    logic        wrap_reg, wrap_next;
    logic [6:0]  bnote_reg, bnote_next, anote_reg, anote_next;
    logic signed [15:0] res_reg, res_next;

    logic signed [33:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic signed [37:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        m_valid_reg, m_valid_next;
    logic [16:0] m_data_reg, m_data_next;

    logic [69:0] prod;
    assign prod = {hi_reg, lo_reg};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_data_reg};

    always_comb
    begin
        logic [32:0] psum;
        logic [STEP_W-1:0] nb, na, nd;
        logic [7:0]  byte_b, byte_a;
        logic [16:0] eb, ea, ed;
        logic        bon, aon, don;
        op_t         drum_start, arp_start;
        logic signed [37:0] t;
        logic signed [18:0] lp;
        logic signed [25:0] vf;
        logic signed [16:0] v;
        logic signed [7:0]  nd8;
        logic signed [15:0] nz;

        state_next = state_reg;   op_next = op_reg;
        phase_next = phase_reg;
        bstep_next = bstep_reg;   astep_next = astep_reg;   dstep_next = dstep_reg;
        benv_next = benv_reg;     aenv_next = aenv_reg;     denv_next = denv_reg;
        mem_next = mem_reg;       saw_next = saw_reg;       sq_pos_next = sq_pos_reg;
        kidx_next = kidx_reg;     x_next = x_reg;           sum_next = sum_reg;
        noise_next = noise_reg;   wrap_next = wrap_reg;     res_next = res_reg;
        bass_on_next = bass_on_reg; arp_on_next = arp_on_reg; drum_on_next = drum_on_reg;
        bnote_next = bnote_reg;   anote_next = anote_reg;
        a_next = a_reg;           b_next = b_reg;
        hi_next = hi_reg;         lo_next = lo_reg;         cnt_next = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;

        psum = {1'b0, phase_reg} + {1'b0, beat_inc_reg};
        nb = (bstep_reg == STEP_W'(STEPS - 1)) ? '0 : bstep_reg + 1'b1;
        na = (astep_reg == STEP_W'(STEPS - 1)) ? '0 : astep_reg + 1'b1;
        nd = (dstep_reg == STEP_W'(STEPS - 1)) ? '0 : dstep_reg + 1'b1;
        if (!psum[32])
        begin
            nb = bstep_reg; na = astep_reg; nd = dstep_reg;
        end
        byte_b = bass_notes_reg[{nb, 3'b000} +: 8];
        byte_a = arp_notes_reg[{na, 3'b000} +: 8];
        eb = (psum[32] && !byte_b[7]) ? ENV_FULL : benv_reg;
        ea = (psum[32] && !byte_a[7]) ? ENV_FULL : aenv_reg;
        ed = (psum[32] && drum_pat_reg[nd]) ? ENV_FULL : denv_reg;
        bon = !byte_b[7] && (eb != '0);
        aon = !byte_a[7] && (ea != '0);
        don = drum_pat_reg[nd] && (ed != '0);

        drum_start = drum_on_reg ? OP_KFREQ : OP_VOL;
        arp_start  = arp_on_reg ? OP_AFREQ : drum_start;

        t  = hi_reg + a_reg * $signed({1'b0, b_reg[3:0]});
        lp = 19'(mem_reg) + 19'($signed(prod[33:16]));
        vf = $signed(prod[40:15]);
        if (vf > 26'sd32768)
            v = 17'sd32768;
        else if (vf < -26'sd32768)
            v = -17'sd32768;
        else
            v = vf[16:0];
        nd8 = $signed({1'b0, noise_reg}) - 8'sd50;
        nz  = (16'(nd8) <<< 8) + (16'(nd8) <<< 6) + (16'(nd8) <<< 3);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    noise_next = (s_tdata[6:0] > 7'd99) ? 7'd99 : s_tdata[6:0];
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (!enable_reg)
                begin
                    res_next = '0;
                    wrap_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    phase_next = psum[31:0];
                    wrap_next = psum[32];
                    bstep_next = nb; astep_next = na; dstep_next = nd;
                    benv_next = eb; aenv_next = ea; denv_next = ed;
                    bass_on_next = bon; arp_on_next = aon; drum_on_next = don;
                    bnote_next = byte_b[6:0];
                    anote_next = byte_a[6:0];
                    sum_next = '0;
                    op_next = bon ? OP_BFREQ : aon ? OP_AFREQ : don ? OP_KFREQ : OP_VOL;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                hi_next = '0;
                lo_next = '0;
                cnt_next = '0;
                state_next = ST_MUL;
                case (op_reg)
                    OP_BFREQ: begin a_next = 34'({2'b00, phase_reg}); b_next = note_freq(bnote_reg); end
                    OP_LPF:   begin a_next = 34'(saw_reg) - 34'(mem_reg); b_next = LPF_COEF; end
                    OP_BX:    begin a_next = 34'(mem_reg); b_next = {15'd0, benv_reg}; end
                    OP_BG:    begin a_next = x_reg; b_next = BASS_GAIN; end
                    OP_BDEC:  begin a_next = 34'({1'b0, benv_reg}); b_next = BASS_DEC; end
                    OP_AFREQ: begin a_next = 34'({2'b00, phase_reg}); b_next = note_freq(anote_reg); end
                    OP_AX:    begin a_next = sq_pos_reg ? 34'(SQ_AMP) : -34'(SQ_AMP);
                                    b_next = {15'd0, aenv_reg}; end
                    OP_AG:    begin a_next = x_reg; b_next = ARP_GAIN; end
                    OP_ADEC:  begin a_next = 34'({1'b0, aenv_reg}); b_next = ARP_DEC; end
                    OP_KFREQ: begin a_next = 34'({2'b00, phase_reg}); b_next = KICK_FREQ; end
                    OP_KX:    begin a_next = 34'(sine64(kidx_reg)); b_next = {15'd0, denv_reg}; end
                    OP_KG:    begin a_next = x_reg; b_next = KICK_GAIN; end
                    OP_NX:    begin a_next = 34'(nz); b_next = {15'd0, denv_reg}; end
                    OP_NG:    begin a_next = x_reg; b_next = NZ_GAIN; end
                    OP_DDEC:  begin a_next = 34'({1'b0, denv_reg}); b_next = DRUM_DEC; end
                    OP_VOL:   begin a_next = 34'(sum_reg); b_next = {16'd0, volume_reg}; end
                    default:  begin a_next = '0; b_next = '0; end
                endcase
            end
            ST_MUL:
            begin
                hi_next = t >>> 4;
                lo_next = {t[3:0], lo_reg[31:4]};
                b_next = b_reg >> 4;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7)
                    state_next = ST_USE;
            end
            ST_USE:
            begin
                state_next = ST_LOAD;
                case (op_reg)
                    OP_BFREQ: begin saw_next = $signed(prod[47:32]); op_next = OP_LPF; end
                    OP_LPF:
                    begin
                        if (lp > 19'sd32767)
                            mem_next = 16'sd32767;
                        else if (lp < -19'sd32768)
                            mem_next = -16'sd32768;
                        else
                            mem_next = lp[15:0];
                        op_next = OP_BX;
                    end
                    OP_BX:    begin x_next = $signed(prod[33:0]); op_next = OP_BG; end
                    OP_BG:    begin sum_next = sum_reg + $signed(prod[51:32]); op_next = OP_BDEC; end
                    OP_BDEC:  begin benv_next = prod[32:16]; op_next = arp_start; end
                    OP_AFREQ:
                    begin
                        sq_pos_next = (prod[47:0] != '0) && !prod[47];
                        op_next = OP_AX;
                    end
                    OP_AX:    begin x_next = $signed(prod[33:0]); op_next = OP_AG; end
                    OP_AG:    begin sum_next = sum_reg + $signed(prod[51:32]); op_next = OP_ADEC; end
                    OP_ADEC:  begin aenv_next = prod[32:16]; op_next = drum_start; end
                    OP_KFREQ: begin kidx_next = prod[47:42]; op_next = OP_KX; end
                    OP_KX:    begin x_next = $signed(prod[33:0]); op_next = OP_KG; end
                    OP_KG:    begin sum_next = sum_reg + $signed(prod[51:32]); op_next = OP_NX; end
                    OP_NX:    begin x_next = $signed(prod[33:0]); op_next = OP_NG; end
                    OP_NG:    begin sum_next = sum_reg + $signed(prod[51:32]); op_next = OP_DDEC; end
                    OP_DDEC:  begin denv_next = prod[32:16]; op_next = OP_VOL; end
                    OP_VOL:
                    begin
                        if (v > 17'sd0)
                            res_next = 16'(v - 17'sd1);
                        else if (v < 17'sd0)
                            res_next = 16'(v + 17'sd1);
                        else
                            res_next = '0;
                        state_next = ST_DONE;
                    end
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next = {wrap_reg, res_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (m_valid_reg && m_tready && !(state_reg == ST_DONE))
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_VOL;
            beat_inc_reg <= '0;
            volume_reg <= 16'd32768;
            bass_notes_reg <= '0;
            arp_notes_reg <= '0;
            drum_pat_reg <= '0;
            enable_reg <= 1'b0;
            phase_reg <= '0;
            bstep_reg <= '0; astep_reg <= '0; dstep_reg <= '0;
            benv_reg <= '0;  aenv_reg <= '0;  denv_reg <= '0;
            mem_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            phase_reg <= phase_next;
            bstep_reg <= bstep_next; astep_reg <= astep_next; dstep_reg <= dstep_next;
            benv_reg <= benv_next;   aenv_reg <= aenv_next;   denv_reg <= denv_next;
            mem_reg <= mem_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BEAT_INC: beat_inc_reg <= cfg_data[31:0];
                    REG_VOLUME:   volume_reg <= cfg_data[15:0];
                    REG_BASS:     bass_notes_reg <= cfg_data;
                    REG_ARP:      arp_notes_reg <= cfg_data;
                    REG_DRUM:     drum_pat_reg <= cfg_data[7:0];
                    REG_ENABLE:   enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        saw_reg <= saw_next;   sq_pos_reg <= sq_pos_next; kidx_reg <= kidx_next;
        x_reg <= x_next;       sum_reg <= sum_next;       noise_reg <= noise_next;
        wrap_reg <= wrap_next; res_reg <= res_next;
        bass_on_reg <= bass_on_next; arp_on_reg <= arp_on_next; drum_on_reg <= drum_on_next;
        bnote_reg <= bnote_next; anote_reg <= anote_next;
        a_reg <= a_next; b_reg <= b_next; hi_reg <= hi_next; lo_reg <= lo_next;
        cnt_reg <= cnt_next;   m_data_reg <= m_data_next;
    end

    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        benv_reg <= ENV_FULL && aenv_reg <= ENV_FULL && denv_reg <= ENV_FULL)
        else $error("envelope above full scale");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_PHASE))
        else $error("accepted request not started");

    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_MUL && cnt_reg == 3'd0))
        else $error("multiplier not started from digit zero");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PHASE && !enable_reg) |=> (res_reg == 16'sd0 && !wrap_reg))
        else $error("disabled request not silent");

endmodule

`default_nettype wire

// ----- tb/sv/tb_step_sequenced_synth_voice.sv -----
// Testbench for the step-sequenced synth voice: random and directed noise values under
// several sequencer settings, checked against a bit-accurate predictor in a scoreboard class.
// Depends on sssv_pkg and step_sequenced_synth_voice.
`timescale 1ns / 1ps

module tb_step_sequenced_synth_voice;
    import sssv_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic               advanced;
    } voice_out_t;

    class voice_scoreboard;
        logic [31:0] beat_inc;
        logic [15:0] volume;
        logic [63:0] bass_seq;
        logic [63:0] arp_seq;
        logic [7:0]  drum_seq;
        logic        run;
        logic [31:0] phase;
        logic [2:0]  bass_pos;
        logic [2:0]  arp_pos;
        logic [2:0]  drum_pos;
        logic [16:0] bass_env;
        logic [16:0] arp_env;
        logic [16:0] drum_env;
        logic signed [15:0] lpf_mem;
        voice_out_t  pending[$];
        int          errors;
        int          checked;
        int          wraps;

        function new();
            beat_inc = 0; volume = 16'd32768; bass_seq = 0; arp_seq = 0;
            drum_seq = 0; run = 0; phase = 0; bass_pos = 0; arp_pos = 0;
            drum_pos = 0; bass_env = 0; arp_env = 0; drum_env = 0; lpf_mem = 0;
            errors = 0; checked = 0; wraps = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_BEAT_INC: beat_inc = val[31:0];
                REG_VOLUME:   volume = val[15:0];
                REG_BASS:     bass_seq = val;
                REG_ARP:      arp_seq = val;
                REG_DRUM:     drum_seq = val[7:0];
                REG_ENABLE:   run = val[0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint x, int k);
            return x >>> k;
        endfunction

        function longint freq_of(logic [6:0] n);
            longint t;
            t = longint'(TOP_OCTAVE[n % 12]);
            return t >> (10 - n / 12);
        endfunction

        function longint sine_at(logic [5:0] i);
            int j;
            j = i[3:0];
            case (i[5:4])
                2'd0: return QUARTER_SINE[j];
                2'd1: return QUARTER_SINE[16 - j];
                2'd2: return -longint'(QUARTER_SINE[j]);
                default: return -longint'(QUARTER_SINE[16 - j]);
            endcase
        endfunction

        function longint term(longint x, longint env, longint g);
            return floor_div(x * env * g, 32);
        endfunction

        function void note_noise(logic [6:0] noise);
            voice_out_t r;
            logic [32:0] nxt;
            logic [7:0]  b, a;
            logic [63:0] prod;
            longint sum, saw, m, sq, nz, v, nv;
            sum = 0;
            r.sample = 0;
            r.advanced = 0;
            if (run)
            begin
                nv = (noise > 99) ? 99 : noise;
                nxt = {1'b0, phase} + {1'b0, beat_inc};
                r.advanced = nxt[32];
                phase = nxt[31:0];
                if (r.advanced)
                begin
                    wraps++;
                    bass_pos++; arp_pos++; drum_pos++;
                    if (!bass_seq[8*bass_pos+7]) bass_env = ENV_FULL;
                    if (!arp_seq[8*arp_pos+7]) arp_env = ENV_FULL;
                    if (drum_seq[drum_pos]) drum_env = ENV_FULL;
                end
                b = bass_seq[8*bass_pos +: 8];
                if (!b[7] && bass_env != 0)
                begin
                    prod = 64'(phase) * 64'(freq_of(b[6:0]));
                    saw = $signed(prod[47:32]);
                    m = lpf_mem + floor_div((saw - lpf_mem) * 6554, 16);
                    if (m > 32767) m = 32767;
                    if (m < -32768) m = -32768;
                    lpf_mem = m;
                    sum += term(m, bass_env, 19661);
                    bass_env = 17'((longint'(bass_env) * 65470) >> 16);
                end
                a = arp_seq[8*arp_pos +: 8];
                if (!a[7] && arp_env != 0)
                begin
                    prod = 64'(phase) * 64'(freq_of(a[6:0]));
                    sq = (prod[47:0] != 0 && !prod[47]) ? 9830 : -9830;
                    sum += term(sq, arp_env, 13107);
                    arp_env = 17'((longint'(arp_env) * 65208) >> 16);
                end
                if (drum_seq[drum_pos] && drum_env != 0)
                begin
                    prod = 64'(phase) * 64'(55 << 16);
                    nz = (nv - 50) * 328;
                    sum += term(sine_at(prod[47:42]), drum_env, 26214);
                    sum += term(nz, drum_env, 13107);
                    drum_env = 17'((longint'(drum_env) * 64881) >> 16);
                end
                v = floor_div(sum * longint'(volume), 15);
                if (v > 32768) v = 32768;
                if (v < -32768) v = -32768;
                r.sample = 16'((v * 32767) / 32768);
            end
            pending.push_back(r);
        endfunction

        function void check_sample(logic [23:0] data);
            voice_out_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected output %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.sample || data[16] !== e.advanced || data[23:17] !== 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp sample %0d adv %0d, got sample %0d adv %0d",
                        e.sample, e.advanced, $signed(data[15:0]), data[16]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    voice_scoreboard sb;
    int  idle_cycles;
    bit  sending_done;
    bit  rx_stall_off;

    step_sequenced_synth_voice u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata);
    end

    // random backpressure on the result side
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            w = rx_stall_off ? 0 : $urandom_range(0, 18);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk iff m_tvalid);
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // valid stays high between back-to-back writes; send_noise and drain drop it
    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk iff cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // valid stays high into a back-to-back request unless a random gap drops it; drain drops it
    task automatic send_noise(input logic [6:0] noise);
        int w;
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        cfg_valid <= 1'b0;
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, noise};
        @(posedge clk iff s_tready);
        sb.note_noise(noise);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_seq();
        logic [63:0] s;
        s = {$urandom, $urandom};
        for (int k = 0; k < 8; k++)
            if ($urandom_range(0, 3) != 0) s[8*k+7] = 1'b0;
        return s;
    endfunction

    task automatic run_phase(input logic [31:0] inc, input logic [15:0] vol,
                             input logic [63:0] bass, input logic [63:0] arp,
                             input logic [7:0] drum, input int n);
        write_cfg(REG_BEAT_INC, inc);
        write_cfg(REG_VOLUME, vol);
        write_cfg(REG_BASS, bass);
        write_cfg(REG_ARP, arp);
        write_cfg(REG_DRUM, drum);
        write_cfg(REG_ENABLE, 64'd1);
        for (int k = 0; k < n; k++)
            send_noise(7'($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 99)));
        drain();
    endtask

    initial
    begin
        logic [31:0] inc;
        logic [15:0] vol;
        sb = new();
        idle_cycles = 0;
        rx_stall_off = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: silence, state held
        send_noise(7'd0);
        send_noise(7'd127);
        drain();
        // extremes of noise, rest steps, top and bottom notes, loud volume
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 64'h7F00_807F_0000_7F00,
                  64'h0000_7F80_007F_0000, 8'hFF, 0);
        foreach (sb.pending[i]) ;
        send_noise(7'd0); send_noise(7'd99); send_noise(7'd100); send_noise(7'd127);
        send_noise(7'd50); send_noise(7'h55); send_noise(7'h2A);
        for (int k = 0; k < 10; k++) send_noise(7'(k * 11));
        drain();
        write_cfg(REG_ENABLE, 64'd0);
        send_noise(7'd77);
        send_noise(7'd3);
        drain();

        run_phase(32'd0, 16'd0, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 8'h00, 20);
        run_phase(32'h8000_0000, 16'd32768, rand_seq(), rand_seq(), 8'h55, 60);
        rx_stall_off = 1;
        run_phase(32'h2000_0000, 16'd65535, rand_seq(), rand_seq(), 8'hAA, 60);
        rx_stall_off = 0;
        for (int p = 0; p < 8; p++)
        begin
            inc = $urandom_range(0, 1) ? {4'h0, 28'($urandom)} + 32'h0100_0000 : $urandom;
            vol = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
            run_phase(inc, vol, rand_seq(), rand_seq(), 8'($urandom), 90);
        end
        write_cfg(REG_ENABLE, 64'd0);
        for (int k = 0; k < 20; k++) send_noise(7'($urandom));
        drain();

        $display("%0d samples checked, %0d beat wraps seen, volume and tempo swept",
            sb.checked, sb.wraps);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
